>>> hw/rtl/lphs_pkg.sv
// lphs_pkg: shared types, constants and the home-slot hash for the page hash set.
// Depends on nothing; used by lphs_slot_ram and linear_probe_page_hash_set_core.
`default_nettype none

package lphs_pkg;

	localparam int SLOT_BITS       = 10;
	localparam int PAGE_SHIFT_BITS = 14;
	localparam int ADDR_BITS       = 32;
	localparam int HASH_WORD       = 32;

	localparam int SLOTS    = 1 << SLOT_BITS;
	localparam int PAGE_W   = ADDR_BITS - PAGE_SHIFT_BITS;
	// stored count never passes half the table, so SLOT_BITS bits hold it
	localparam int COUNT_W  = SLOT_BITS;

	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int SLOT_OUT_W  = 10;
	localparam int COUNT_OUT_W = 10;

	localparam logic [HASH_WORD-1:0] FIB_MUL = 32'h9e37_79b1;

	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	typedef logic [SLOT_BITS-1:0] slot_idx_t;

	typedef struct packed {
		logic              vld;
		logic [PAGE_W-1:0] page;
	} slot_t;

	// single-port access: read every cycle at addr, write when we is set
	typedef struct packed {
		logic      we;
		slot_idx_t addr;
		slot_t     wdata;
	} ram_req_t;

	// Fibonacci hash: top SLOT_BITS of the 32-bit product
	function automatic slot_idx_t home_of(input logic [PAGE_W-1:0] page);
		logic [HASH_WORD-1:0] prod;
		prod = HASH_WORD'(page) * FIB_MUL;
		return prod[HASH_WORD-1 -: SLOT_BITS];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lphs_slot_ram.sv
// lphs_slot_ram: single-port slot store, registered read.
// Depends on lphs_pkg (slot_t, ram_req_t, SLOTS).
`default_nettype none

module lphs_slot_ram
	import lphs_pkg::*;
(
	input  wire logic     clk,
	input  wire ram_req_t req,
	output slot_t         rdata
);

	slot_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/linear_probe_page_hash_set_core.sv
// linear_probe_page_hash_set_core: page-number set in a linear-probed hash table.
// Depends on lphs_pkg and lphs_slot_ram.
`default_nettype none

// Channel  Handshake             Beat contents
// -------  --------------------  ---------------------------------------
// req      req_valid/req_ready   func, address
// rsp      rsp_valid/rsp_ready   status, slot_index, entry_count
//
// After reset the slot store is swept empty, one slot a cycle, while req_ready
// stays low. Lookup, insert and remove probes read one slot a cycle, each read
// issued ahead of the compare. A remove hit then runs the backward shift: read,
// hash and compare/move for each occupied slot examined, then a read of the
// empty slot that ends the run and a clear of the final hole. Insert refusal
// and unused codes go straight to the result.
// One item at a time; a finished beat waits in the rsp register while the
// next request is taken, and the core stalls only if a new result is ready
// before the old one has left.

module linear_probe_page_hash_set_core
	import lphs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_ready,
	input  wire logic [FUNC_W-1:0]      func,
	input  wire logic [ADDR_BITS-1:0]   address,
	output logic                        rsp_valid,
	input  wire logic                   rsp_ready,
	output logic [STATUS_W-1:0]         status,
	output logic [SLOT_OUT_W-1:0]       slot_index,
	output logic [COUNT_OUT_W-1:0]      entry_count
);

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_PROBE   = 3'd2;
	localparam logic [2:0] S_SH_RD   = 3'd3;
	localparam logic [2:0] S_SH_HASH = 3'd4;
	localparam logic [2:0] S_SH_CMP  = 3'd5;
	localparam logic [2:0] S_SH_CLR  = 3'd6;
	localparam logic [2:0] S_RESULT  = 3'd7;

	localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);
	localparam logic [COUNT_W-1:0] HALF_LOAD = COUNT_W'(SLOTS / 2);

	logic [2:0]           state_q;
	logic [FUNC_W-1:0]    func_q;
	logic [PAGE_W-1:0]    page_q;
	slot_idx_t            ptr_q;       // next probe read; also clear sweep index
	slot_idx_t            ptr_s1;      // slot whose data arrives this cycle
	logic                 chk_vld_s1;  // a probe read is in flight
	slot_idx_t            chk_q;       // probes compared so far
	slot_idx_t            hole_q;
	slot_idx_t            j_q;
	slot_idx_t            sh_n_q;
	slot_idx_t            home_q;
	slot_t                ent_q;
	logic [COUNT_W-1:0]   count_q;
	logic [STATUS_W-1:0]  res_status_q;
	slot_idx_t            res_slot_q;

	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  rsp_status_q;
	logic [SLOT_OUT_W-1:0]  rsp_slot_q;
	logic [COUNT_OUT_W-1:0] rsp_count_q;

	ram_req_t ram_req;
	slot_t    rd_data;

	logic req_fire;
	logic rsp_free;
	logic hit_now;
	logic empty_now;
	logic exhaust_now;
	logic [PAGE_W-1:0] req_page;

	lphs_slot_ram u_slot_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rd_data)
	);

	assign req_ready   = (state_q == S_IDLE);
	assign req_fire    = req_valid && req_ready;
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign req_page    = address[ADDR_BITS-1:PAGE_SHIFT_BITS];

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign slot_index  = rsp_slot_q;
	assign entry_count = rsp_count_q;

	// probe verdict on the slot whose read data just came back
	assign hit_now     = chk_vld_s1 && rd_data.vld && (rd_data.page == page_q)
	                     && (func_q != FUNC_INSERT);
	assign empty_now   = chk_vld_s1 && !rd_data.vld;
	assign exhaust_now = chk_vld_s1 && rd_data.vld && !hit_now && (chk_q == LAST_SLOT);

	// memory port: one access a cycle; writes only where no read is needed
	always_comb begin
		ram_req       = '0;
		ram_req.addr  = ptr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_req.we   = 1'b1;
				ram_req.addr = ptr_q;
			end
			S_PROBE: begin
				if (empty_now && (func_q == FUNC_INSERT)) begin
					ram_req.we         = 1'b1;
					ram_req.addr       = ptr_s1;
					ram_req.wdata.vld  = 1'b1;
					ram_req.wdata.page = page_q;
				end else begin
					ram_req.addr = ptr_q;
				end
			end
			S_SH_RD: begin
				ram_req.addr = j_q;
			end
			S_SH_CMP: begin
				// entry moves back into the hole; its old slot becomes the hole
				if ((j_q - home_q) >= (j_q - hole_q)) begin
					ram_req.we    = 1'b1;
					ram_req.addr  = hole_q;
					ram_req.wdata = ent_q;
				end
			end
			S_SH_CLR: begin
				ram_req.we   = 1'b1;
				ram_req.addr = hole_q;
			end
			default: begin
				ram_req.addr = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			func_q       <= FUNC_LOOKUP;
			page_q       <= '0;
			ptr_q        <= '0;
			ptr_s1       <= '0;
			chk_vld_s1   <= 1'b0;
			chk_q        <= '0;
			hole_q       <= '0;
			j_q          <= '0;
			sh_n_q       <= '0;
			home_q       <= '0;
			ent_q        <= '0;
			count_q      <= '0;
			res_status_q <= STAT_MISS;
			res_slot_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STAT_MISS;
			rsp_slot_q   <= '0;
			rsp_count_q  <= '0;
		end else begin
			// in S_RESULT the load below decides rsp_valid_q on its own
			if (rsp_valid_q && rsp_ready && state_q != S_RESULT) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (req_fire) begin
						func_q       <= func;
						page_q       <= req_page;
						ptr_q        <= home_of(req_page);
						chk_q        <= '0;
						chk_vld_s1   <= 1'b0;
						res_slot_q   <= '0;
						priority if (func == FUNC_INSERT && count_q >= HALF_LOAD) begin
							res_status_q <= STAT_FULL;
							state_q      <= S_RESULT;
						end else if (func == FUNC_LOOKUP || func == FUNC_INSERT
						             || func == FUNC_REMOVE) begin
							res_status_q <= STAT_MISS;
							state_q      <= S_PROBE;
						end else begin
							res_status_q <= STAT_MISS;
							state_q      <= S_RESULT;
						end
					end
				end

				S_PROBE: begin
					ptr_q      <= ptr_q + 1'b1;
					ptr_s1     <= ptr_q;
					if (chk_vld_s1) begin
						chk_q <= chk_q + 1'b1;
					end
					priority if (empty_now && func_q == FUNC_INSERT) begin
						chk_vld_s1   <= 1'b0;
						count_q      <= count_q + 1'b1;
						res_status_q <= STAT_OK;
						res_slot_q   <= ptr_s1;
						state_q      <= S_RESULT;
					end else if (hit_now && func_q == FUNC_REMOVE) begin
						chk_vld_s1   <= 1'b0;
						count_q      <= count_q - 1'b1;
						res_status_q <= STAT_OK;
						res_slot_q   <= ptr_s1;
						hole_q       <= ptr_s1;
						j_q          <= ptr_s1 + 1'b1;
						sh_n_q       <= '0;
						state_q      <= S_SH_RD;
					end else if (hit_now) begin
						chk_vld_s1   <= 1'b0;
						res_status_q <= STAT_OK;
						res_slot_q   <= ptr_s1;
						state_q      <= S_RESULT;
					end else if (empty_now || exhaust_now) begin
						chk_vld_s1 <= 1'b0;
						state_q    <= S_RESULT;
					end else begin
						chk_vld_s1 <= 1'b1;
					end
				end

				S_SH_RD: begin
					if (sh_n_q == LAST_SLOT) begin
						state_q <= S_SH_CLR;
					end else begin
						state_q <= S_SH_HASH;
					end
				end

				S_SH_HASH: begin
					ent_q  <= rd_data;
					home_q <= home_of(rd_data.page);
					if (rd_data.vld) begin
						state_q <= S_SH_CMP;
					end else begin
						state_q <= S_SH_CLR;
					end
				end

				S_SH_CMP: begin
					if ((j_q - home_q) >= (j_q - hole_q)) begin
						hole_q <= j_q;
					end
					j_q     <= j_q + 1'b1;
					sh_n_q  <= sh_n_q + 1'b1;
					state_q <= S_SH_RD;
				end

				S_SH_CLR: begin
					state_q <= S_RESULT;
				end

				S_RESULT: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_slot_q   <= SLOT_OUT_W'(res_slot_q);
						rsp_count_q  <= COUNT_OUT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for linear_probe_page_hash_set_core.
// Keeps a shadow copy of the slot table to predict every response beat; needs lphs_pkg.

module testbench;
	import lphs_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// no-accept cycles tolerated: covers the sweep after reset, a long backward
	// shift at half load and a run of receiver stalls, several times over
	localparam int IDLE_LIMIT = 20000;

	typedef logic [PAGE_W-1:0] page_t;

	typedef struct {
		logic [FUNC_W-1:0]    op;
		logic [ADDR_BITS-1:0] addr;
	} req_beat_t;

	typedef struct {
		logic [STATUS_W-1:0]    st;
		logic [SLOT_OUT_W-1:0]  slot;
		logic [COUNT_OUT_W-1:0] cnt;
	} rsp_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	logic [FUNC_W-1:0]      func;
	logic [ADDR_BITS-1:0]   address;
	logic                   rsp_valid;
	logic                   rsp_ready;
	logic [STATUS_W-1:0]    status;
	logic [SLOT_OUT_W-1:0]  slot_index;
	logic [COUNT_OUT_W-1:0] entry_count;

	linear_probe_page_hash_set_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.address     (address),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.slot_index  (slot_index),
		.entry_count (entry_count)
	);

	// shadow of the slot store and the entry count
	logic  shadow_vld  [SLOTS];
	page_t shadow_page [SLOTS];
	int    shadow_count;
	int    refused_n;     // inserts refused at half load, seen so far

	req_beat_t req_pending_q[$];   // beats waiting for the driver
	rsp_beat_t rsp_due_q[$];       // predicted responses, oldest first
	page_t     key_log[$];         // pages sent for insert and not yet removed
	page_t     pool[$];            // small key set with heavy home collisions

	int pushed_n;
	int accepted_n;
	int errors;
	int idle_cycles;
	int src_idle_pct;
	int snk_idle_pct;
	bit req_taken;

	// ---------------------------------------------------------------- prediction

	// Fibonacci hash: top SLOT_BITS bits of the 32-bit product
	function automatic slot_idx_t fib_home(page_t pg);
		logic [HASH_WORD-1:0] prod;
		prod = HASH_WORD'(pg) * FIB_MUL;
		return prod[HASH_WORD-1 -: SLOT_BITS];
	endfunction

	// linear probe from home; stops at the first empty slot or after a full lap
	function automatic bit shadow_find(page_t pg, output slot_idx_t at);
		slot_idx_t i;
		int n;
		i = fib_home(pg);
		at = '0;
		for (n = 0; n < SLOTS; n++) begin
			if (!shadow_vld[i])
				return 1'b0;
			if (shadow_page[i] == pg) begin
				at = i;
				return 1'b1;
			end
			i = i + 1'b1;
		end
		return 1'b0;
	endfunction

	// backward shift: pull later cluster members into the hole when their
	// probe distance allows, moving the hole along with them
	function automatic void shadow_close_gap(slot_idx_t hole);
		slot_idx_t j;
		slot_idx_t d_home;
		slot_idx_t d_hole;
		int n;
		j = hole + 1'b1;
		for (n = 0; n + 1 < SLOTS && shadow_vld[j]; n++) begin
			d_home = j - fib_home(shadow_page[j]);
			d_hole = j - hole;
			if (d_home >= d_hole) begin
				shadow_page[hole] = shadow_page[j];
				shadow_vld[hole]  = 1'b1;
				shadow_vld[j]     = 1'b0;
				shadow_page[j]    = '0;
				hole = j;
			end
			j = j + 1'b1;
		end
	endfunction

	// applies one request beat to the shadow table, returns the response due
	function automatic rsp_beat_t page_set_step(logic [FUNC_W-1:0] op,
			logic [ADDR_BITS-1:0] addr);
		page_t pg;
		slot_idx_t at;
		slot_idx_t i;
		rsp_beat_t r;
		pg = addr[ADDR_BITS-1:PAGE_SHIFT_BITS];
		r.st = STAT_MISS;
		r.slot = '0;
		case (op)
			FUNC_LOOKUP: begin
				if (shadow_find(pg, at)) begin
					r.st = STAT_OK;
					r.slot = SLOT_OUT_W'(at);
				end
			end
			FUNC_INSERT: begin
				if ((shadow_count + 1) * 2 > SLOTS) begin
					r.st = STAT_FULL;
					refused_n++;
				end else begin
					// no duplicate check: first empty slot from home
					i = fib_home(pg);
					while (shadow_vld[i])
						i = i + 1'b1;
					shadow_vld[i] = 1'b1;
					shadow_page[i] = pg;
					shadow_count++;
					r.st = STAT_OK;
					r.slot = SLOT_OUT_W'(i);
				end
			end
			FUNC_REMOVE: begin
				if (shadow_find(pg, at)) begin
					shadow_vld[at] = 1'b0;
					shadow_page[at] = '0;
					if (shadow_count > 0)
						shadow_count--;
					shadow_close_gap(at);
					r.st = STAT_OK;
					r.slot = SLOT_OUT_W'(at);
				end
			end
			default: begin
				// unused code: table untouched, reported as a miss
			end
		endcase
		r.cnt = COUNT_OUT_W'(shadow_count);
		return r;
	endfunction

	// ---------------------------------------------------------------- clock

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- driver
	// Inputs move on the falling edge only. A beat stays on the bus until the
	// rising edge at which req_valid and req_ready are both high.

	always @(negedge clk) begin
		req_beat_t nxt;
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				req_taken = 1'b0;
				if (req_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = req_pending_q.pop_front();
					req_valid <= 1'b1;
					func      <= nxt.op;
					address   <= nxt.addr;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// ---------------------------------------------------------------- monitor
	// Both channels are sampled on the rising edge. An accepted request beat is
	// run through the shadow table right away; a response beat is checked
	// against the oldest prediction. Also the no-progress watchdog.

	always @(posedge clk) begin
		rsp_beat_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (req_valid && req_ready) begin
				rsp_due_q.push_back(page_set_step(func, address));
				accepted_n++;
				req_taken = 1'b1;
				moved = 1'b1;
			end
			if (rsp_valid && rsp_ready) begin
				moved = 1'b1;
				if (rsp_due_q.size() == 0) begin
					$error("response beat with nothing due: status %0d slot %0d count %0d",
						status, slot_index, entry_count);
					errors++;
				end else begin
					want = rsp_due_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (slot_index !== want.slot) begin
						$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
						errors++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
						errors++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// generator steps just after the rising edge, once all edge activity settled
	task automatic tick();
		@(posedge clk);
		#1;
	endtask

	// one beat of lookahead keeps the shadow count close to current
	task automatic queue_req(logic [FUNC_W-1:0] op, logic [ADDR_BITS-1:0] addr);
		req_beat_t b;
		while (req_pending_q.size() != 0)
			tick();
		b.op = op;
		b.addr = addr;
		req_pending_q.push_back(b);
		pushed_n++;
	endtask

	// hold the sender until every beat is in and every response is out
	task automatic settle();
		while (accepted_n != pushed_n || rsp_due_q.size() != 0)
			tick();
	endtask

	function automatic logic [ADDR_BITS-1:0] addr_of(page_t pg);
		return {pg, PAGE_SHIFT_BITS'($urandom)};
	endfunction

	function automatic page_t rand_page();
		return PAGE_W'($urandom);
	endfunction

	function automatic page_t page_with_home(slot_idx_t target);
		page_t pg;
		do
			pg = rand_page();
		while (fib_home(pg) != target);
		return pg;
	endfunction

	function automatic page_t pool_page();
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	// a page that is probably stored; taken out of the log when it is to be removed
	function automatic page_t logged_page(bit take);
		int idx;
		page_t pg;
		if (key_log.size() == 0)
			return rand_page();
		idx = $urandom_range(0, key_log.size() - 1);
		pg = key_log[idx];
		if (take)
			key_log.delete(idx);
		return pg;
	endfunction

	task automatic send_insert(page_t pg);
		key_log.push_back(pg);
		queue_req(FUNC_INSERT, addr_of(pg));
	endtask

	initial begin
		page_t hot;
		page_t wrap0;
		page_t wrap1;
		page_t wrap2;
		page_t zero_home;
		int k;
		int roll;

		arst_n       = 1'b0;
		req_valid    = 1'b0;
		rsp_ready    = 1'b0;
		func         = FUNC_LOOKUP;
		address      = '0;
		req_taken    = 1'b0;
		pushed_n     = 0;
		accepted_n   = 0;
		errors       = 0;
		idle_cycles  = 0;
		refused_n    = 0;
		shadow_count = 0;
		src_idle_pct = 12;
		snk_idle_pct = 88;
		for (k = 0; k < SLOTS; k++) begin
			shadow_vld[k]  = 1'b0;
			shadow_page[k] = '0;
		end

		// key pool: one long cluster, keys homed at the top slots so probes and
		// shifts wrap to slot 0, keys homed at slot 0, and the page extremes
		hot = rand_page();
		pool.push_back(hot);
		for (k = 0; k < 5; k++)
			pool.push_back(page_with_home(fib_home(hot)));
		for (k = 0; k < 4; k++)
			pool.push_back(page_with_home(slot_idx_t'(SLOTS - 1)));
		for (k = 0; k < 2; k++)
			pool.push_back(page_with_home(slot_idx_t'(SLOTS - 2)));
		for (k = 0; k < 2; k++)
			pool.push_back(page_with_home('0));
		pool.push_back('0);
		pool.push_back('1);
		for (k = 0; k < 5; k++)
			pool.push_back(rand_page());
		wrap0     = page_with_home(slot_idx_t'(SLOTS - 1));
		wrap1     = page_with_home(slot_idx_t'(SLOTS - 1));
		wrap2     = page_with_home(slot_idx_t'(SLOTS - 1));
		zero_home = page_with_home('0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-table misses, unused code, page extremes, duplicate
		// insert and remove of the first copy, absent-key remove, and a cluster
		// on the last slot whose backward shift wraps to slot 0
		queue_req(FUNC_LOOKUP, 32'h0000_0000);
		queue_req(FUNC_REMOVE, 32'h0000_0000);
		queue_req(FUNC_UNUSED, 32'h0000_0000);
		key_log.push_back('0);
		queue_req(FUNC_INSERT, 32'h0000_0000);
		key_log.push_back('0);
		queue_req(FUNC_INSERT, 32'h0000_3fff);
		key_log.push_back('1);
		queue_req(FUNC_INSERT, 32'hffff_ffff);
		queue_req(FUNC_LOOKUP, 32'hffff_c000);
		queue_req(FUNC_LOOKUP, 32'h0000_3fff);
		queue_req(FUNC_REMOVE, 32'h0000_1234);
		queue_req(FUNC_LOOKUP, 32'h0000_0000);
		queue_req(FUNC_REMOVE, addr_of(page_t'(1)));
		queue_req(FUNC_UNUSED, 32'hffff_ffff);
		send_insert(wrap0);
		send_insert(wrap1);
		send_insert(wrap2);
		send_insert(zero_home);
		queue_req(FUNC_REMOVE, addr_of(wrap0));
		queue_req(FUNC_LOOKUP, addr_of(wrap2));
		queue_req(FUNC_LOOKUP, addr_of(zero_home));
		queue_req(FUNC_REMOVE, addr_of(wrap1));
		queue_req(FUNC_LOOKUP, addr_of(wrap2));
		queue_req(FUNC_REMOVE, 32'h0000_0000);
		queue_req(FUNC_LOOKUP, 32'h0000_0000);
		settle();

		// phase 1: slow receiver, small colliding pool, lots of duplicates
		for (k = 0; k < 25; k++) begin
			roll = $urandom_range(99);
			if (roll < 35)
				send_insert(pool_page());
			else if (roll < 65)
				queue_req(FUNC_LOOKUP, addr_of(pool_page()));
			else if (roll < 95)
				queue_req(FUNC_REMOVE, addr_of(pool_page()));
			else if (roll < 98)
				queue_req(FUNC_UNUSED, $urandom());
			else
				queue_req(FUNC_LOOKUP, $urandom());
		end
		settle();

		// phase 2: slow sender, fill to half load and push past it
		src_idle_pct = 88;
		snk_idle_pct = 12;
		for (k = 0; k < 1200 && refused_n < 6; k++) begin
			roll = $urandom_range(99);
			if (roll < 1)
				queue_req(FUNC_UNUSED, $urandom());
			else if (roll < 2)
				queue_req(FUNC_REMOVE, addr_of(logged_page(1'b1)));
			else if (roll < 4)
				queue_req(FUNC_LOOKUP, addr_of(logged_page(1'b0)));
			else if (roll < 5)
				queue_req(FUNC_LOOKUP, $urandom());
			else if (roll < 15)
				send_insert(pool_page());
			else
				send_insert(rand_page());
		end
		settle();

		// phase 3: no idling either side, mostly removes from the full table
		src_idle_pct = 0;
		snk_idle_pct = 0;
		for (k = 0; k < 30; k++) begin
			roll = $urandom_range(99);
			if (roll < 55)
				queue_req(FUNC_REMOVE, addr_of(logged_page(1'b1)));
			else if (roll < 70)
				queue_req(FUNC_LOOKUP, addr_of(logged_page(1'b0)));
			else if (roll < 77)
				queue_req(FUNC_LOOKUP, $urandom());
			else if (roll < 92)
				send_insert(roll[0] ? pool_page() : rand_page());
			else if (roll < 96)
				queue_req(FUNC_REMOVE, $urandom());
			else
				queue_req(FUNC_UNUSED, $urandom());
		end
		settle();
		repeat (64) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
